FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/ffra_pkg.sv
// Types, codes and constants of the first-fit region allocator.
`timescale 1ns / 1ps
package ffra_pkg;
   localparam int SLOTS_DEFAULT = 256;
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_ALLOC = 2'd1;
   localparam logic [1:0] FUNC_FREE  = 2'd2;
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOFIT    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_IGNORED  = 3'd4;
   localparam logic [31:0] PAGE_MASK = 32'h0000_0FFF;
   localparam logic [31:0] ADDR_MAX  = 32'hFFFF_FFFF;

   // Entry carried around the ring of cells.
   typedef struct packed {
      logic [31:0] address;
      logic [31:0] length;
      logic        used;
   } slot_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_WRITE, S_RESP
   } state_type;

   // Per-cycle command from the sequencer to the ring.
   typedef struct packed {
      logic        rotate;
      logic        write;
      slot_type    data;
   } ring_ctl_type;
endpackage

FILE: hw/rtl/ffra_cell.sv
// One slot of the rotating ring: holds an entry and passes it on.
`timescale 1ns / 1ps
module ffra_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               rotate,
   input  ffra_pkg::slot_type prev,
   output ffra_pkg::slot_type slot
);
   ffra_pkg::slot_type slot_ff, slot_in;

   // Take the neighbour's entry on each shift.
   always_comb begin
      slot_in = rotate ? prev : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;
endmodule

FILE: hw/rtl/ffra_ring.sv
// Ring of slot cells; the head entry can be replaced as it re-enters at the tail.
`timescale 1ns / 1ps
module ffra_ring #(
   parameter int SLOTS = ffra_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffra_pkg::ring_ctl_type ctl,
   output ffra_pkg::slot_type     head
);
   ffra_pkg::slot_type chain [SLOTS];
   ffra_pkg::slot_type feed;

   // Head leaving the ring re-enters at the tail, replaced on a write.
   always_comb begin
      feed = ctl.write ? ctl.data : chain[0];
   end

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         ffra_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .rotate (ctl.rotate),
            .prev   ((g == SLOTS - 1) ? feed : chain[(g + 1) % SLOTS]),
            .slot   (chain[g])
         );
      end
   endgenerate

   assign head = chain[0];
endmodule

FILE: hw/rtl/first_fit_region_allocator.sv
// Top level of the first-fit region allocator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One beat in, one beat out, one item at a time. The slots live in a ring of
// SLOTS cells that rotates one place a cycle, in the scan and write-back states
// only, past a single head. Every item takes one full revolution to scan and a
// second revolution to write back, after which the response beat is valid. No
// new request is taken until the response has been handed back, and the
// response waits for as long as rsp_tready stays low.
module first_fit_region_allocator #(
   parameter int SLOTS = ffra_pkg::SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // func
   input  logic [159:0] req_tdata,  // address[63:0], length[127:64], region_type[159:128]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,  // status
   output logic [31:0]  rsp_tdata   // block_address
);
   localparam int CW = $clog2(SLOTS);
   localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

   ffra_pkg::state_type    state_ff, state_in;
   ffra_pkg::ring_ctl_type ctl;
   ffra_pkg::slot_type     head;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    func_ff;
   logic [63:0]   addr_ff, len_ff;
   logic [31:0]   type_ff;
   logic [31:0]   size;
   // Scan results: fit index, empty index, free match index.
   logic          fit_v_ff, emp_v_ff, fr_v_ff, fit_v_in, emp_v_in, fr_v_in;
   logic [CW-1:0] fit_i_ff, emp_i_ff, fr_i_ff, fit_i_in, emp_i_in, fr_i_in;
   logic [31:0]   fit_a_ff, fit_l_ff, fit_a_in, fit_l_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   blk_ff, blk_in;
   logic [31:0]   add_len;
   logic          add_ok;
   logic [31:0]   remain;
   logic [CW-1:0] e_idx;
   logic          e_ok;

   ffra_ring #(.SLOTS(SLOTS)) u_ring (
      .clock (clock), .reset (reset), .ctl (ctl), .head (head)
   );

   // Round the request up to whole pages.
   assign size = (len_ff[31:0] + ffra_pkg::PAGE_MASK) & ~ffra_pkg::PAGE_MASK;
   // Clip and qualify an added region.
   always_comb begin
      logic [32:0] room;
      room = {1'b0, ffra_pkg::ADDR_MAX} - {1'b0, addr_ff[31:0]};
      add_len = (len_ff > {31'd0, room}) ? room[31:0] : len_ff[31:0];
      add_ok = (type_ff == 32'd1) && (len_ff != 64'd0) && (addr_ff[63:32] == 32'd0)
               && (addr_ff[31:0] != 32'd0) && (add_len != 32'd0);
   end
   assign remain = fit_l_ff - size;
   always_comb begin
      if (remain == 32'd0 && (!emp_v_ff || fit_i_ff < emp_i_ff)) begin
         e_idx = fit_i_ff;
         e_ok  = 1'b1;
      end else begin
         e_idx = emp_i_ff;
         e_ok  = emp_v_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffra_pkg::S_IDLE:  if (req_tvalid) state_in = ffra_pkg::S_SCAN;
         ffra_pkg::S_SCAN:  if (cnt_ff == LAST) state_in = ffra_pkg::S_WRITE;
         ffra_pkg::S_WRITE: if (cnt_ff == LAST) state_in = ffra_pkg::S_RESP;
         ffra_pkg::S_RESP:  if (rsp_tready) state_in = ffra_pkg::S_IDLE;
         default:           state_in = ffra_pkg::S_IDLE;
      endcase
   end

   // Scan bookkeeping and decision.
   always_comb begin
      cnt_in = cnt_ff;
      fit_v_in = fit_v_ff; fit_i_in = fit_i_ff; fit_a_in = fit_a_ff; fit_l_in = fit_l_ff;
      emp_v_in = emp_v_ff; emp_i_in = emp_i_ff;
      fr_v_in = fr_v_ff; fr_i_in = fr_i_ff;
      st_in = st_ff; blk_in = blk_ff;
      if (state_ff == ffra_pkg::S_IDLE) begin
         cnt_in = '0; fit_v_in = 1'b0; emp_v_in = 1'b0; fr_v_in = 1'b0;
      end else if (state_ff == ffra_pkg::S_SCAN) begin
         cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + 1'b1;
         if (!emp_v_ff && head.address == 32'd0) begin
            emp_v_in = 1'b1; emp_i_in = cnt_ff;
         end
         if (!fit_v_ff && head.address != 32'd0 && !head.used && head.length >= size) begin
            fit_v_in = 1'b1; fit_i_in = cnt_ff;
            fit_a_in = head.address; fit_l_in = head.length;
         end
         if (!fr_v_ff && head.address == addr_ff[31:0] && addr_ff[31:0] != 32'd0) begin
            fr_v_in = 1'b1; fr_i_in = cnt_ff;
         end
         if (cnt_ff == LAST) begin
            blk_in = 32'd0;
            case (func_ff)
               ffra_pkg::FUNC_ADD: st_in = !add_ok ? ffra_pkg::ST_IGNORED :
                  (emp_v_in ? ffra_pkg::ST_OK : ffra_pkg::ST_FULL);
               ffra_pkg::FUNC_FREE: st_in = (fr_v_in && addr_ff[63:32] == 32'd0) ?
                  ffra_pkg::ST_OK : ffra_pkg::ST_NOTFOUND;
               ffra_pkg::FUNC_ALLOC: st_in = ffra_pkg::ST_NOFIT;
               default: st_in = ffra_pkg::ST_IGNORED;
            endcase
         end
      end else if (state_ff == ffra_pkg::S_WRITE) begin
         cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + 1'b1;
         if (cnt_ff == '0 && func_ff == ffra_pkg::FUNC_ALLOC) begin
            if (len_ff > 64'hFFFF_F000 || !fit_v_ff) st_in = ffra_pkg::ST_NOFIT;
            else if (!e_ok) st_in = ffra_pkg::ST_FULL;
            else begin st_in = ffra_pkg::ST_OK; blk_in = fit_a_ff; end
         end
      end
   end

   // Ring rotation during scan and write-back; slot writes during the write revolution.
   always_comb begin
      logic go;
      ctl.rotate = (state_ff == ffra_pkg::S_SCAN) || (state_ff == ffra_pkg::S_WRITE);
      ctl.write = 1'b0;
      ctl.data = head;
      go = (state_ff == ffra_pkg::S_WRITE);
      case (func_ff)
         ffra_pkg::FUNC_ADD:
            if (go && st_ff == ffra_pkg::ST_OK && cnt_ff == emp_i_ff) begin
               ctl.write = 1'b1;
               ctl.data = '{address: addr_ff[31:0], length: add_len, used: 1'b0};
            end
         ffra_pkg::FUNC_FREE:
            if (go && st_ff == ffra_pkg::ST_OK && cnt_ff == fr_i_ff) begin
               ctl.write = 1'b1; ctl.data.used = 1'b0;
            end
         ffra_pkg::FUNC_ALLOC:
            if (go && len_ff <= 64'hFFFF_F000 && fit_v_ff && e_ok) begin
               if (cnt_ff == e_idx) begin
                  ctl.write = 1'b1;
                  ctl.data = '{address: fit_a_ff, length: size, used: 1'b1};
               end else if (cnt_ff == fit_i_ff) begin
                  ctl.write = 1'b1;
                  ctl.data = '{address: (remain == 32'd0) ? 32'd0 : fit_a_ff + size,
                               length: remain, used: head.used};
               end
            end
         default: ctl.write = 1'b0;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_tready = (state_ff == ffra_pkg::S_IDLE);
      rsp_tvalid = (state_ff == ffra_pkg::S_RESP);
      rsp_tuser  = st_ff;
      rsp_tdata  = blk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffra_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Capture the beat and hold scan results.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         addr_ff <= req_tdata[63:0];
         len_ff  <= req_tdata[127:64];
         type_ff <= req_tdata[159:128];
      end
      fit_v_ff <= fit_v_in; fit_i_ff <= fit_i_in; fit_a_ff <= fit_a_in; fit_l_ff <= fit_l_in;
      emp_v_ff <= emp_v_in; emp_i_ff <= emp_i_in;
      fr_v_ff <= fr_v_in; fr_i_ff <= fr_i_in;
      st_ff <= st_in; blk_ff <= blk_in;
   end

   `ASSERT_IMPLY(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_IMPLY(a_blk_ok, clock, reset, rsp_tvalid && rsp_tdata != 32'd0,
                 rsp_tuser == ffra_pkg::ST_OK)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tuser) && $stable(rsp_tdata))
endmodule
